// ----- rtl/tmtw_pkg.sv -----
// Package for the text-mode terminal writer.
// Holds field widths, operation and register codes and character constants.
// No dependencies; every other file imports it.
`default_nettype none

package tmtw_pkg;

    // Field widths of the command and result transfers.
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int RCOL_W    = 7;
    localparam int RROW_W    = 6;
    localparam int OCOL_W    = 7;
    localparam int OROW_W    = 6;
    localparam int CELL_W    = 16;

    // Configuration register widths and port shape.
    localparam int COLS_W     = 8;
    localparam int ROWS_W     = 7;
    localparam int FILLC_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default screen memory geometry.
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL = 2'd2;

    // Register values after reset.
    localparam logic [COLS_W-1:0]  RST_COLS = 8'd80;
    localparam logic [ROWS_W-1:0]  RST_ROWS = 7'd25;
    localparam logic [FILLC_W-1:0] RST_FILL = 8'd7;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // Character codes with a meaning of their own.
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

endpackage

`default_nettype wire

// ----- rtl/tmtw_in_if.sv -----
// Command channel of the text-mode terminal writer.
// Carries valid, ready and the command fields; depends on tmtw_pkg.
`default_nettype none

interface tmtw_in_if
    import tmtw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  char_color;
    logic [RCOL_W-1:0]   read_col;
    logic [RROW_W-1:0]   read_row;

    modport source (
        output valid, func, char_code, char_color, read_col, read_row,
        input  ready
    );

    modport sink (
        input  valid, func, char_code, char_color, read_col, read_row,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/tmtw_out_if.sv -----
// Result channel of the text-mode terminal writer.
// Carries valid, ready and the result fields; depends on tmtw_pkg.
`default_nettype none

interface tmtw_out_if
    import tmtw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [OCOL_W-1:0]   cursor_col;
    logic [OROW_W-1:0]   cursor_row;
    logic [CELL_W-1:0]   cell_value;
    logic                did_scroll;

    modport source (
        output valid, cursor_col, cursor_row, cell_value, did_scroll,
        input  ready
    );

    modport sink (
        input  valid, cursor_col, cursor_row, cell_value, did_scroll,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/text_mode_terminal_writer_unit.sv -----
// Top level of the text-mode terminal writer: sequencer, cursor and result register.
// Depends on tmtw_pkg, tmtw_in_if, tmtw_out_if and tmtw_screen_ram.
//
// A character-cell terminal that keeps its screen in one synchronous memory of
// MAX_COLS x MAX_ROWS cells, cell (col,row) at address row*MAX_COLS+col. A put,
// read or no-op command is accepted (a read is issued to the memory here), then
// in the execute state updates the cursor and writes the cell before its result
// is registered. A scroll walks the used area through the single write port: it
// copies each cell of rows 1 to rows-1 up one row, then blanks the bottom row.
// A clear blanks every cell of the used area. No command is taken while a
// command is in progress; a finished result may wait in the output register
// while the next command is accepted. Geometry registers are clamped to
// 1..MAX_COLS and 1..MAX_ROWS, and the cursor is pulled inside the geometry at
// the start of each command.
`default_nettype none

module text_mode_terminal_writer_unit
    import tmtw_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    tmtw_in_if.sink                    i_cmd,
    tmtw_out_if.source                 o_res
);

    localparam int CXW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CYW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ECW   = $clog2(MAX_COLS + 1);
    localparam int ERW   = $clog2(MAX_ROWS + 1);
    localparam int DEPTH = MAX_COLS * MAX_ROWS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_SCOPY = 3'd2;
    localparam logic [2:0] ST_FILL  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    function automatic logic [ECW-1:0] clamp_cols(input logic [COLS_W-1:0] v);
        logic [ECW-1:0] res;
        if (v == '0) begin
            res = ECW'(1);
        end else if (int'(v) > MAX_COLS) begin
            res = ECW'(MAX_COLS);
        end else begin
            res = ECW'(v);
        end
        return res;
    endfunction

    function automatic logic [ERW-1:0] clamp_rows(input logic [ROWS_W-1:0] v);
        logic [ERW-1:0] res;
        if (v == '0) begin
            res = ERW'(1);
        end else if (int'(v) > MAX_ROWS) begin
            res = ERW'(MAX_ROWS);
        end else begin
            res = ERW'(v);
        end
        return res;
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [CYW-1:0] y,
                                              input logic [CXW-1:0] x);
        return AW'(int'(y) * MAX_COLS + int'(x));
    endfunction

    // Registers.
    logic [ECW-1:0]     r_cols;
    logic [ERW-1:0]     r_rows;
    logic [FILLC_W-1:0] r_fill;
    logic [2:0]         r_state, n_state;
    logic [CXW-1:0]     r_cur_x, n_cur_x;
    logic [CYW-1:0]     r_cur_y, n_cur_y;
    logic [FUNC_W-1:0]  r_func;
    logic [CHAR_W-1:0]  r_char;
    logic [COLOR_W-1:0] r_color;
    logic               r_rd_ok;
    logic [CYW-1:0]     r_srow, n_srow;
    logic [CXW-1:0]     r_scol, n_scol;
    logic               r_wpend, n_wpend;
    logic [AW-1:0]      r_waddr, n_waddr;
    logic [CELL_W-1:0]  r_res_cell, n_res_cell;
    logic               r_res_scroll, n_res_scroll;
    logic               r_out_valid, n_out_valid;
    logic [OCOL_W-1:0]  r_out_col;
    logic [OROW_W-1:0]  r_out_row;
    logic [CELL_W-1:0]  r_out_cell;
    logic               r_out_scroll;

    // Combinational helpers.
    logic               accept;
    logic               can_out;
    logic               load_out;
    logic [CXW-1:0]     sat_x;
    logic [CYW-1:0]     sat_y;
    logic [ECW-1:0]     x_inc;
    logic [ERW-1:0]     y_inc;
    logic [CYW-1:0]     last_row;
    logic [CXW-1:0]     last_col;
    logic [CELL_W-1:0]  blank;
    logic               exec_we;
    logic [CELL_W-1:0]  exec_data;
    logic               fill_we;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    assign accept   = i_cmd.valid && i_cmd.ready;
    assign can_out  = !r_out_valid || o_res.ready;
    assign blank    = {r_fill, CH_BLANK};
    assign last_row = CYW'(r_rows - ERW'(1));
    assign last_col = CXW'(r_cols - ECW'(1));
    assign x_inc    = ECW'(r_cur_x) + ECW'(1);
    assign y_inc    = ERW'(r_cur_y) + ERW'(1);

    // Cursor pulled inside the geometry in use.
    assign sat_x = (ECW'(r_cur_x) >= r_cols) ? last_col : r_cur_x;
    assign sat_y = (ERW'(r_cur_y) >= r_rows) ? last_row : r_cur_y;

    assign i_cmd.ready = (r_state == ST_IDLE);

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_srow       = r_srow;
        n_scol       = r_scol;
        n_wpend      = 1'b0;
        n_waddr      = r_waddr;
        n_res_cell   = r_res_cell;
        n_res_scroll = r_res_scroll;
        exec_we      = 1'b0;
        exec_data    = blank;
        fill_we      = 1'b0;
        load_out     = 1'b0;
        ram_raddr    = addr_of(CYW'(i_cmd.read_row), CXW'(i_cmd.read_col));

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cur_x      = sat_x;
                    n_cur_y      = sat_y;
                    n_res_cell   = '0;
                    n_res_scroll = 1'b0;
                    n_state      = ST_EXEC;
                end
            end

            ST_EXEC: begin
                n_state = ST_DONE;
                case (r_func)
                    FUNC_PUT: begin
                        if (r_char == CH_NEWLINE) begin
                            n_cur_x = '0;
                            if (y_inc >= r_rows) begin
                                n_res_scroll = 1'b1;
                            end else begin
                                n_cur_y = CYW'(y_inc);
                            end
                        end else if (r_char == CH_BACKSPACE) begin
                            exec_we = 1'b1;
                            if (r_cur_x != '0) begin
                                n_cur_x = r_cur_x - CXW'(1);
                            end else if (r_cur_y != '0) begin
                                n_cur_y = r_cur_y - CYW'(1);
                            end
                        end else begin
                            exec_we   = 1'b1;
                            exec_data = {r_color, r_char};
                            if (x_inc >= r_cols) begin
                                n_cur_x = '0;
                                if (y_inc >= r_rows) begin
                                    n_res_scroll = 1'b1;
                                end else begin
                                    n_cur_y = CYW'(y_inc);
                                end
                            end else begin
                                n_cur_x = CXW'(x_inc);
                            end
                        end
                    end
                    FUNC_READ: begin
                        n_res_cell = r_rd_ok ? ram_rdata : '0;
                    end
                    FUNC_CLEAR: begin
                        n_srow  = '0;
                        n_scol  = '0;
                        n_state = ST_FILL;
                    end
                    default: begin
                    end
                endcase
                // A scroll copies rows up, or only blanks a single-row screen.
                if (n_res_scroll) begin
                    n_cur_y = last_row;
                    n_scol  = '0;
                    if (r_rows == ERW'(1)) begin
                        n_srow  = '0;
                        n_state = ST_FILL;
                    end else begin
                        n_srow  = CYW'(1);
                        n_state = ST_SCOPY;
                    end
                end
            end

            ST_SCOPY: begin
                // Read a cell; its write to the row above follows in the next cycle.
                ram_raddr = addr_of(r_srow, r_scol);
                n_wpend   = 1'b1;
                n_waddr   = addr_of(CYW'(r_srow - CYW'(1)), r_scol);
                if (r_scol == last_col) begin
                    n_scol = '0;
                    if (r_srow == last_row) begin
                        n_state = ST_FILL;
                    end else begin
                        n_srow = r_srow + CYW'(1);
                    end
                end else begin
                    n_scol = r_scol + CXW'(1);
                end
            end

            ST_FILL: begin
                // Holds off while the last copied cell is still being written.
                if (!r_wpend) begin
                    fill_we = 1'b1;
                    if (r_scol == last_col) begin
                        n_scol = '0;
                        if (r_srow == last_row) begin
                            n_state = ST_DONE;
                        end else begin
                            n_srow = r_srow + CYW'(1);
                        end
                    end else begin
                        n_scol = r_scol + CXW'(1);
                    end
                end
            end

            ST_DONE: begin
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Hand the result to the output register as soon as it is free.
        if (n_state == ST_DONE && can_out) begin
            load_out = 1'b1;
            n_state  = ST_IDLE;
        end
    end

    // Memory write port: copy, then blank fill, then the command's own write.
    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = addr_of(r_cur_y, r_cur_x);
        ram_wdata = exec_data;
        if (r_wpend) begin
            ram_waddr = r_waddr;
            ram_wdata = ram_rdata;
        end else if (fill_we) begin
            ram_waddr = addr_of(r_srow, r_scol);
            ram_wdata = blank;
        end else if (!exec_we) begin
            ram_we = 1'b0;
        end
    end

    assign n_out_valid = load_out || (r_out_valid && !o_res.ready);

    tmtw_screen_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_wpend     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_wpend     <= n_wpend;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers, held in their clamped form.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= clamp_cols(RST_COLS);
            r_rows <= clamp_rows(RST_ROWS);
            r_fill <= RST_FILL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS: r_cols <= clamp_cols(i_cfg_data[COLS_W-1:0]);
                CFG_ROWS: r_rows <= clamp_rows(i_cfg_data[ROWS_W-1:0]);
                CFG_FILL: r_fill <= i_cfg_data[FILLC_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Command and sequencer payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_cmd.func;
            r_char  <= i_cmd.char_code;
            r_color <= i_cmd.char_color;
            r_rd_ok <= (int'(i_cmd.read_col) < int'(r_cols)) &&
                       (int'(i_cmd.read_row) < int'(r_rows));
        end
        r_srow       <= n_srow;
        r_scol       <= n_scol;
        r_waddr      <= n_waddr;
        r_res_cell   <= n_res_cell;
        r_res_scroll <= n_res_scroll;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_col    <= OCOL_W'(n_cur_x);
            r_out_row    <= OROW_W'(n_cur_y);
            r_out_cell   <= n_res_cell;
            r_out_scroll <= n_res_scroll;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.cursor_col = r_out_col;
    assign o_res.cursor_row = r_out_row;
    assign o_res.cell_value = r_out_cell;
    assign o_res.did_scroll = r_out_scroll;

    // The memory is never written while the block waits for a command.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !ram_we)
        else $error("screen memory written while idle");

    // The three write sources never compete for the port.
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_wpend, fill_we, exec_we}))
        else $error("two writes to the screen memory in one cycle");

    // A result only appears at the end of a command.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) != ST_IDLE))
        else $error("result loaded without a command in progress");

    // An accepted command is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted command not executed");

endmodule

`default_nettype wire

// ----- rtl/tmtw_screen_ram.sv -----
// Screen memory: one write port and one read port with registered read data.
// Depends on tmtw_pkg for the cell width.
`default_nettype none

module tmtw_screen_ram
    import tmtw_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS * DEF_MAX_ROWS,
    parameter int AW    = 13
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [CELL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data.
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire
